// File: hw/rtl/mexp_pkg.sv
// Shared constants and types for the modular exponentiation block.
package mexp_pkg;
   localparam int WIDTH = 20;
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIV_EXP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PUB_EXP = 2'd2;
   localparam int CNT_W = $clog2(WIDTH + 1);
   localparam logic OP_TRANSFORM = 1'b0;
   localparam logic OP_VERIFY = 1'b1;

   // Datapath commands from the controller.
   localparam int CMD_W = 3;
   localparam logic [CMD_W-1:0] CMD_NONE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD = 3'd1; // capture operands
   localparam logic [CMD_W-1:0] CMD_RED = 3'd2;  // start base mod n
   localparam logic [CMD_W-1:0] CMD_MUL = 3'd3;  // start acc*sq
   localparam logic [CMD_W-1:0] CMD_SQR = 3'd4;  // start sq*sq
   localparam logic [CMD_W-1:0] CMD_SHIFT = 3'd5; // exponent >>= 1

   // Result source: the accumulator, or a constant for the early exits.
   localparam int SEL_W = 2;
   localparam logic [SEL_W-1:0] SEL_ACC = 2'd0;
   localparam logic [SEL_W-1:0] SEL_ZERO = 2'd1;
   localparam logic [SEL_W-1:0] SEL_ONE = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic mul_busy;
      logic base_zero;
      logic expo_zero;
      logic mod_small;
      logic expo_lsb;
   } status_type;
endpackage

// File: hw/rtl/mexp_modmul.sv
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle.
module mexp_modmul (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [mexp_pkg::WIDTH-1:0] a,
   input  logic [mexp_pkg::WIDTH-1:0] b,
   input  logic [mexp_pkg::WIDTH-1:0] m,
   output logic                      busy,
   output logic [mexp_pkg::WIDTH-1:0] prod
);
   import mexp_pkg::*;

   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] a_ff, a_in, b_ff, b_in, m_ff, m_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [WIDTH:0] mx, dbl, sub1, add1, sub2;

   // Operand b must already be below m, and m must be at least two.
   always_comb begin
      mx = {1'b0, m_ff};
      dbl = {acc_ff, 1'b0};
      sub1 = (dbl >= mx) ? dbl - mx : dbl;
      add1 = a_ff[WIDTH-1] ? sub1 + {1'b0, b_ff} : sub1;
      sub2 = (add1 >= mx) ? add1 - mx : add1;
   end

   always_comb begin
      acc_in = acc_ff;
      a_in = a_ff;
      b_in = b_ff;
      m_in = m_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         acc_in = '0;
         a_in = a;
         b_in = b;
         m_in = m;
         cnt_in = CNT_W'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = sub2[WIDTH-1:0];
         a_in = {a_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff <= a_in;
      b_ff <= b_in;
      m_ff <= m_in;
   end

   assign busy = busy_ff;
   assign prod = acc_ff;
endmodule

// File: hw/rtl/mexp_datapath.sv
// Operand registers, exponent shifter and the shared modular multiplier.
module mexp_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  mexp_pkg::cmd_type          cmd,
   input  logic [mexp_pkg::SEL_W-1:0] res_sel,
   input  logic                       req_opcode,
   input  logic [mexp_pkg::WIDTH-1:0] req_value,
   input  logic [mexp_pkg::WIDTH-1:0] req_expected_hash,
   input  logic [mexp_pkg::WIDTH-1:0] modulus,
   input  logic [mexp_pkg::WIDTH-1:0] private_exponent,
   input  logic [mexp_pkg::WIDTH-1:0] public_exponent,
   output mexp_pkg::status_type       status,
   output logic [mexp_pkg::WIDTH-1:0] res_value,
   output logic                       res_match
);
   import mexp_pkg::*;

   logic [WIDTH-1:0] base_ff, expo_ff, acc_ff, sq_ff, mod_ff, hash_ff;
   logic op_ff;
   logic dst_acc_ff; // the running product goes to acc, otherwise to sq
   logic mul_start, mul_busy, busy_d_ff;
   logic [WIDTH-1:0] ma, mb, prod;
   logic done_pulse;

   always_comb begin
      mul_start = 1'b0;
      ma = sq_ff;
      mb = sq_ff;
      unique case (cmd.op)
         CMD_RED: begin mul_start = 1'b1; ma = base_ff; mb = WIDTH'(1); end
         CMD_MUL: begin mul_start = 1'b1; ma = acc_ff; mb = sq_ff; end
         CMD_SQR: begin mul_start = 1'b1; ma = sq_ff; mb = sq_ff; end
         default: ;
      endcase
   end

   mexp_modmul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(ma), .b(mb),
      .m(mod_ff), .busy(mul_busy), .prod(prod)
   );

   assign done_pulse = busy_d_ff && !mul_busy;

   always_ff @(posedge clock) begin
      if (reset) busy_d_ff <= 1'b0;
      else busy_d_ff <= mul_busy;
      if (cmd.op == CMD_LOAD) begin
         base_ff <= req_value;
         hash_ff <= req_expected_hash;
         op_ff <= req_opcode;
         expo_ff <= req_opcode ? public_exponent : private_exponent;
         mod_ff <= modulus;
         acc_ff <= WIDTH'(1);
      end
      if (cmd.op == CMD_SHIFT) expo_ff <= expo_ff >> 1;
      if (mul_start) dst_acc_ff <= (cmd.op == CMD_MUL);
      if (done_pulse) begin
         if (dst_acc_ff) acc_ff <= prod;
         else sq_ff <= prod;
      end
   end

   assign status.mul_busy = mul_busy;
   assign status.base_zero = (base_ff == '0);
   assign status.expo_zero = (expo_ff == '0);
   assign status.mod_small = (mod_ff < WIDTH'(2));
   assign status.expo_lsb = expo_ff[0];

   // The early exits override the accumulator.
   always_comb begin
      unique case (res_sel)
         SEL_ZERO: res_value = '0;
         SEL_ONE: res_value = WIDTH'(1);
         default: res_value = acc_ff;
      endcase
   end

   assign res_match = (op_ff == OP_VERIFY) && (res_value == hash_ff);
endmodule

// File: hw/rtl/mexp_ctrl.sv
// Sequencer for square-and-multiply.
module mexp_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  mexp_pkg::status_type       status,
   output mexp_pkg::cmd_type          cmd,
   output logic [mexp_pkg::SEL_W-1:0] res_sel
);
   import mexp_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0, S_CHECK = 3'd1, S_RED = 3'd2,
      S_MUL = 3'd3, S_SQR = 3'd4, S_WAIT = 3'd5, S_SHIFT = 3'd6, S_OUT = 3'd7;

   logic [2:0] state_ff, state_in, ret_ff, ret_in;
   logic [SEL_W-1:0] sel_ff, sel_in;

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      sel_in = sel_ff;
      cmd.op = CMD_NONE;
      unique case (state_ff)
         S_IDLE: if (req_valid) begin cmd.op = CMD_LOAD; state_in = S_CHECK; end
         S_CHECK: begin
            sel_in = SEL_ACC;
            if (status.base_zero) begin sel_in = SEL_ZERO; state_in = S_OUT; end
            else if (status.expo_zero) begin sel_in = SEL_ONE; state_in = S_OUT; end
            else if (status.mod_small) begin sel_in = SEL_ZERO; state_in = S_OUT; end
            else begin cmd.op = CMD_RED; ret_in = S_MUL; state_in = S_WAIT; end
         end
         S_MUL: begin
            if (status.expo_zero) state_in = S_OUT;
            else if (status.expo_lsb) begin
               cmd.op = CMD_MUL; ret_in = S_SQR; state_in = S_WAIT;
            end else state_in = S_SQR;
         end
         S_SQR: begin cmd.op = CMD_SQR; ret_in = S_SHIFT; state_in = S_WAIT; end
         S_WAIT: if (!status.mul_busy) state_in = ret_ff;
         S_SHIFT: begin cmd.op = CMD_SHIFT; state_in = S_MUL; end
         S_OUT: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff <= S_IDLE;
         sel_ff <= SEL_ACC;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         sel_ff <= sel_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign res_sel = sel_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !rsp_valid)
      else $error("result shown while idle");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped under stall");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT && !status.mul_busy) |=> state_ff != S_WAIT)
      else $error("stuck waiting on multiplier");
endmodule

// File: hw/rtl/modular_exponentiation_verify.sv
// Top level of the modular exponentiation and signature verify block.
//
//   channel | ports                                     | direction
//   req     | req_valid/req_stall, opcode, value, hash  | in
//   rsp     | rsp_valid/rsp_stall, result, hash_match   | out
//   csr     | csr_write, csr_index, csr_data            | in
//
// One word is in flight at a time; req_stall is high from the cycle after
// acceptance until the result word has left. Each modular multiply is an
// issue state followed by a wait on the bit-serial multiplier. The base
// reduction costs one multiply; each exponent bit costs a square and a shift
// step, plus a multiply when the bit is set. Zero base, zero exponent or a
// modulus below two skip the multiplier. Reset is synchronous and restores
// the register defaults. The result word holds while rsp_stall is high.
module modular_exponentiation_verify (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_opcode,
   input  logic [mexp_pkg::WIDTH-1:0] req_value,
   input  logic [mexp_pkg::WIDTH-1:0] req_expected_hash,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [mexp_pkg::WIDTH-1:0] rsp_result,
   output logic                       rsp_hash_match,
   input  logic                       csr_write,
   input  logic [mexp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mexp_pkg::WIDTH-1:0] csr_data
);
   import mexp_pkg::*;

   logic [WIDTH-1:0] modulus_ff, priv_ff, pub_ff;
   logic [SEL_W-1:0] res_sel;
   cmd_type cmd;
   status_type status;

   // Configuration registers; writes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= WIDTH'(2);
         priv_ff <= WIDTH'(1);
         pub_ff <= WIDTH'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MODULUS: modulus_ff <= csr_data;
            CSR_PRIV_EXP: priv_ff <= csr_data;
            CSR_PUB_EXP: pub_ff <= csr_data;
            default: ;
         endcase
      end
   end

   mexp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .status(status), .cmd(cmd),
      .res_sel(res_sel)
   );

   // The datapath picks the result source and compares it with the hash.
   mexp_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .res_sel(res_sel),
      .req_opcode(req_opcode), .req_value(req_value),
      .req_expected_hash(req_expected_hash),
      .modulus(modulus_ff), .private_exponent(priv_ff), .public_exponent(pub_ff),
      .status(status), .res_value(rsp_result), .res_match(rsp_hash_match)
   );
endmodule

// File: dv/modular_exponentiation_verify_checker.sv
// Result checker for the modular exponentiation block: predicts and compares every result word.
`timescale 1ns / 100ps
module modular_exponentiation_verify_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_opcode,
   input  logic [mexp_pkg::WIDTH-1:0]     req_value,
   input  logic [mexp_pkg::WIDTH-1:0]     req_expected_hash,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [mexp_pkg::WIDTH-1:0]     rsp_result,
   input  logic                           rsp_hash_match,
   input  logic                           csr_write,
   input  logic [mexp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mexp_pkg::WIDTH-1:0]     csr_data,
   output int                             fail_count,
   output int                             pending,
   output int                             checked
);
   import mexp_pkg::*;

   typedef struct {
      logic [WIDTH-1:0] result;
      logic             hash_match;
   } power_word_type;

   power_word_type   power_queue[$];
   logic [WIDTH-1:0] mod_reg;
   logic [WIDTH-1:0] priv_reg;
   logic [WIDTH-1:0] pub_reg;

   // Square-and-multiply with the block's corner rules for zero operands.
   function automatic logic [WIDTH-1:0] power_mod(logic [WIDTH-1:0] base,
         logic [WIDTH-1:0] expo, logic [WIDTH-1:0] n);
      logic [63:0] acc;
      logic [63:0] sq;
      logic [WIDTH-1:0] e;
      if (base == 0) return '0;
      if (expo == 0) return WIDTH'(1);
      if (n < 2) return '0;
      acc = 64'd1;
      sq = base % n;
      e = expo;
      while (e != 0) begin
         if (e[0]) acc = (acc * sq) % n;
         sq = (sq * sq) % n;
         e = e >> 1;
      end
      return acc[WIDTH-1:0];
   endfunction

   always @(posedge clock) begin
      power_word_type want;
      int errs;
      errs = 0;
      if (reset) begin
         mod_reg <= WIDTH'(2);
         priv_reg <= WIDTH'(1);
         pub_reg <= WIDTH'(1);
         power_queue.delete();
         fail_count <= 0;
         checked <= 0;
         pending <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_MODULUS: mod_reg <= csr_data;
               CSR_PRIV_EXP: priv_reg <= csr_data;
               CSR_PUB_EXP: pub_reg <= csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            want.result = power_mod(req_value,
               (req_opcode == OP_VERIFY) ? pub_reg : priv_reg, mod_reg);
            want.hash_match = (req_opcode == OP_VERIFY) &&
               (want.result == req_expected_hash);
            power_queue.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            checked <= checked + 1;
            if (power_queue.size() == 0) begin
               $error("result word with nothing outstanding: result %0d", rsp_result);
               errs++;
            end else begin
               want = power_queue.pop_front();
               if (rsp_result !== want.result) begin
                  $error("result: expected %0d, actual %0d", want.result, rsp_result);
                  errs++;
               end
               if (rsp_hash_match !== want.hash_match) begin
                  $error("hash_match: expected %0d, actual %0d",
                     want.hash_match, rsp_hash_match);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending <= power_queue.size();
      end
   end
endmodule

// File: dv/modular_exponentiation_verify_tb.sv
// Testbench top for the modular exponentiation block: stimulus, register setup and verdict.
`timescale 1ns / 100ps
module modular_exponentiation_verify_tb;
   import mexp_pkg::*;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic             req_opcode = OP_TRANSFORM;
   logic [WIDTH-1:0] req_value = '0;
   logic [WIDTH-1:0] req_expected_hash = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [WIDTH-1:0] rsp_result;
   logic             rsp_hash_match;
   logic             csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MODULUS;
   logic [WIDTH-1:0] csr_data = '0;

   int fail_count;
   int pending;
   int checked;

   // Percentage of cycles in which each side idles; zero during the calm stretch.
   int idle_pct = 30;
   // Set by the stimulus to make the receiver hold off for a long stretch.
   bit hold_request = 1'b0;
   int words_sent = 0;
   int settings_used = 0;
   int idle_cycles = 0;

   // Shadow copy of the modulus and public exponent, so that verify words
   // can be built with a matching hash when the result is easy to foresee.
   logic [WIDTH-1:0] cur_mod = WIDTH'(2);
   logic [WIDTH-1:0] cur_pub = WIDTH'(1);

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES = 3000;

   always #5 clock = ~clock;

   modular_exponentiation_verify DUT (.*);

   modular_exponentiation_verify_checker CHECK (.*);

   // The receiver stalls at random, except during the calm stretch, and once
   // holds off for a long stretch so the block fills and stalls its input.
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         rsp_stall = ($urandom_range(99) < idle_pct);
         @(negedge clock);
      end
   end

   // The watchdog counts cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL modular_exponentiation_verify");
            $finish;
         end
      end
   end

   // Offers one word after a random gap and returns at the falling edge that
   // follows its acceptance. Valid stays high between back-to-back words.
   task automatic send_word(logic op, logic [WIDTH-1:0] val, logic [WIDTH-1:0] hash);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_opcode = op;
      req_value = val;
      req_expected_hash = hash;
      do @(posedge clock); while (req_stall);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [WIDTH-1:0] data);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = data;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   // Registers change only once the block has drained every outstanding word.
   task automatic load_key(logic [WIDTH-1:0] n, logic [WIDTH-1:0] priv,
         logic [WIDTH-1:0] pub);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      write_reg(CSR_MODULUS, n);
      write_reg(CSR_PRIV_EXP, priv);
      write_reg(CSR_PUB_EXP, pub);
      cur_mod = n;
      cur_pub = pub;
      settings_used++;
   endtask

   // A random transform or verify word; a verify hash matches about half the time
   // when the result is predictable (public exponent of 0 or 1), and is random otherwise.
   task automatic send_random_word();
      logic [WIDTH-1:0] val;
      logic [WIDTH-1:0] hash;
      logic             op;
      val = ($urandom_range(15) == 0) ? '0 : WIDTH'($urandom);
      op = 1'($urandom_range(1));
      hash = WIDTH'($urandom);
      if (op == OP_VERIFY && $urandom_range(1) && val != 0 && cur_mod >= 2) begin
         if (cur_pub == 1) hash = val % cur_mod;
         else if (cur_pub == 0) hash = WIDTH'(1);
      end
      send_word(op, val, hash);
   endtask

   initial begin
      logic [WIDTH-1:0] n;
      logic [WIDTH-1:0] priv;
      logic [WIDTH-1:0] pub;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. Reset keys first: modulus 2 and both exponents 1.
      send_word(OP_TRANSFORM, '0, '0);
      send_word(OP_TRANSFORM, '1, '0);
      send_word(OP_VERIFY, WIDTH'(3), WIDTH'(1));
      send_word(OP_VERIFY, WIDTH'(4), WIDTH'(1));

      // Widest modulus and private exponent; public exponent 1 for easy matches.
      load_key('1, '1, WIDTH'(1));
      send_word(OP_TRANSFORM, '1, '1);
      send_word(OP_TRANSFORM, WIDTH'(2), '0);
      send_word(OP_VERIFY, 20'd123456, 20'd123456);
      send_word(OP_VERIFY, '1, '0);
      send_word(OP_VERIFY, '0, '0);

      // Zero exponent: nonzero values give 1, a zero value still gives 0.
      load_key(20'd1000, '0, '0);
      send_word(OP_TRANSFORM, 20'd77, '0);
      send_word(OP_TRANSFORM, '0, '0);
      send_word(OP_VERIFY, '1, WIDTH'(1));
      send_word(OP_VERIFY, '0, WIDTH'(1));

      // Modulus of one gives 0, except that a zero exponent still gives 1.
      load_key(WIDTH'(1), WIDTH'(5), '0);
      send_word(OP_TRANSFORM, WIDTH'(7), '0);
      send_word(OP_VERIFY, WIDTH'(7), WIDTH'(1));
      send_word(OP_VERIFY, '0, '0);

      // Modulus of zero is outside the legal range but must still give 0.
      load_key('0, '1, WIDTH'(3));
      send_word(OP_TRANSFORM, WIDTH'(9), '0);
      send_word(OP_VERIFY, '1, '0);
      send_word(OP_VERIFY, '0, '0);

      // Random part: a run of key settings, mostly full-width moduli, some
      // small ones, with exponents occasionally pinned to 0, 1 or all ones.
      for (int phase = 0; phase < 9; phase++) begin
         case ($urandom_range(3))
            0: n = WIDTH'($urandom_range(255, 2));
            default: n = WIDTH'($urandom_range(20'hFFFFF, 2));
         endcase
         priv = ($urandom_range(7) == 0) ? '1 : WIDTH'($urandom);
         case ($urandom_range(5))
            0: pub = '0;
            1, 2: pub = WIDTH'(1);
            3: pub = '1;
            default: pub = WIDTH'($urandom);
         endcase
         load_key(n, priv, pub);
         for (int k = 0; k < 75; k++) begin
            // One calm stretch with no idling on either side.
            idle_pct = (phase == 3) ? 0 : 30;
            // Midway through, the receiver holds off while words keep coming.
            if (phase == 5 && k == 10) hold_request = 1'b1;
            send_random_word();
         end
         idle_pct = 30;
      end

      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);

      $display("Sent %0d words over %0d key settings; %0d results checked.",
         words_sent, settings_used, checked);
      $display("Covered zero base, zero exponent, moduli of 0, 1 and full width.");
      if (fail_count == 0) begin
         $display("PASS modular_exponentiation_verify");
      end else begin
         $display("FAIL modular_exponentiation_verify");
      end
      $finish;
   end
endmodule
